// ===== design/ntc_pkg.sv =====
`default_nettype none

package ntc_pkg;

  localparam int SAMPLE_BITS_DEFAULT   = 12;
  localparam int LOG_FRAC_BITS_DEFAULT = 16;
  localparam int GUARD_BITS            = 8;
  localparam int ROM_FRAC              = 60;
  localparam int KELVIN_BITS           = 13;
  localparam int STATUS_BITS           = 2;
  localparam logic [KELVIN_BITS-1:0] KELVIN_MAX = 13'd6000;
  // 298.15 K in tenths (2981.5), doubled so it stays an integer
  localparam logic [12:0] BASE_TENTHS_X2 = 13'd5963;
  localparam int SCALE_K_BITS = 24;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_DIVIDER  = 2'd1,
    STATUS_ZERO_READING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CHECK,
    CS_LN,
    CS_RESID,
    CS_ROUND,
    CS_MUL,
    CS_SCALE,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic ln_step;
    logic ln_resid;
    logic round_en;
    logic mul_en;
    logic scale_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fault;
    logic last_step;
  } dp_status_t;

  // shift-subtract division, used only for elaboration-time constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atanh(1/d) in Q60
  function automatic logic [63:0] atanh_inv(input logic [63:0] d);
    logic [63:0] zp;
    logic [63:0] s;
    logic [63:0] k;
    zp = udiv64(64'd1 << ROM_FRAC, d);
    s  = '0;
    k  = 64'd1;
    while (zp != 64'd0) begin
      s  = s + udiv64(zp, k);
      zp = udiv64(udiv64(zp, d), d);
      k  = k + 64'd2;
    end
    return s;
  endfunction

  function automatic logic [63:0] round_q60(input logic [63:0] x, input int w);
    int sh;
    sh = ROM_FRAC - w;
    return (x + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // ln(1 + 2^-i) in Qw, entry 0 unused
  function automatic logic [63:0] ln_step_q(input int i, input int w);
    logic [63:0] x;
    x = '0;
    if (i != 0) begin
      x = round_q60(64'd2 * atanh_inv((64'd1 << (i + 1)) + 64'd1), w);
    end
    return x;
  endfunction

  function automatic logic [63:0] ln2_q(input int w);
    return round_q60(64'd2 * atanh_inv(64'd3), w);
  endfunction

  // round(10 * 2^16 / ln(25/24))
  function automatic logic [63:0] calc_scale_k();
    logic [63:0] ln_q40;
    ln_q40 = (64'd2 * atanh_inv(64'd49) + (64'd1 << 19)) >> 20;
    return udiv64((64'd10 << 56) + (ln_q40 >> 1), ln_q40);
  endfunction

  localparam logic [63:0] SCALE_K_FULL = calc_scale_k();
  localparam logic [SCALE_K_BITS-1:0] SCALE_K = SCALE_K_FULL[SCALE_K_BITS-1:0];

endpackage

`default_nettype wire

// ===== design/ntc_in_if.sv =====
`default_nettype none

interface ntc_in_if import ntc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic                   sample_a_ok;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic                   sample_b_ok;

  modport source (
    output valid, sample_a, sample_a_ok, sample_b, sample_b_ok,
    input  ready
  );

  modport sink (
    input  valid, sample_a, sample_a_ok, sample_b, sample_b_ok,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/ntc_out_if.sv =====
`default_nettype none

interface ntc_out_if import ntc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [KELVIN_BITS-1:0] kelvin_tenths;
  logic [STATUS_BITS-1:0] status;

  modport source (
    output valid, kelvin_tenths, status,
    input  ready
  );

  modport sink (
    input  valid, kelvin_tenths, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/ntc_ln_unit.sv =====
`default_nettype none

// shift-and-add natural log: n = 2^k * m, then greedy product of (1 + 2^-i)
module ntc_ln_unit import ntc_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEFAULT,
  localparam int W  = LOG_FRAC_BITS + GUARD_BITS,
  localparam int NW = SAMPLE_BITS + 1,
  localparam int KB = $clog2(NW),
  localparam int IW = $clog2(W + 1),
  localparam int YW = W + KB + 1
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          step,
  input  wire logic          resid,
  input  wire logic [NW-1:0] n,
  input  wire logic [IW-1:0] shift_idx,
  input  wire logic [W-1:0]  step_val,
  output logic      [YW-1:0] y
);

  localparam logic [63:0]  Ln2Full = ln2_q(W);
  localparam logic [W-1:0] Ln2     = Ln2Full[W-1:0];

  logic [W:0]      m_r;
  logic [W:0]      p_r;
  logic [YW-1:0]   y_r;
  logic [KB-1:0]   k;
  logic [NW+W-1:0] norm;
  logic [KB+W-1:0] k_ln2;
  logic [W+1:0]    t;

  always_comb begin
    k = '0;
    for (int j = 0; j < NW; j++) begin
      if (n[j]) k = KB'(j);
    end
  end

  assign norm  = {n, {W{1'b0}}} >> k;
  assign k_ln2 = k * Ln2;
  assign t     = {1'b0, p_r} + ({1'b0, p_r} >> shift_idx);

  always_ff @(posedge clk) begin
    if (load) begin
      m_r <= norm[W:0];
      p_r <= {1'b1, {W{1'b0}}};
      y_r <= YW'(k_ln2);
    end else if (step) begin
      if (t <= {1'b0, m_r}) begin
        p_r <= t[W:0];
        y_r <= y_r + YW'(step_val);
      end
    end else if (resid) begin
      y_r <= y_r + YW'(m_r - p_r);
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ===== design/ntc_datapath.sv =====
`default_nettype none

module ntc_datapath import ntc_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output dp_status_t                  status,
  input  wire logic [SAMPLE_BITS-1:0] sample_a,
  input  wire logic                   sample_a_ok,
  input  wire logic [SAMPLE_BITS-1:0] sample_b,
  input  wire logic                   sample_b_ok,
  output logic      [KELVIN_BITS-1:0] kelvin_tenths,
  output status_t                     status_code
);

  localparam int W  = LOG_FRAC_BITS + GUARD_BITS;
  localparam int NW = SAMPLE_BITS + 1;
  localparam int KB = $clog2(NW);
  localparam int IW = $clog2(W + 1);
  localparam int YW = W + KB + 1;
  localparam int LW = YW + 1 - GUARD_BITS;
  localparam int PW = LW + SCALE_K_BITS;
  localparam int VW = PW + 2;
  localparam int QS = LOG_FRAC_BITS + 16;
  localparam logic [VW-1:0] BaseV = VW'(BASE_TENTHS_X2) << (LOG_FRAC_BITS + 15);

  logic [SAMPLE_BITS-1:0] held_a_r;
  logic [SAMPLE_BITS-1:0] held_b_r;
  logic [IW-1:0]          step_cnt_r;
  logic                   lr_neg_r;
  logic [LW-1:0]          lr_mag_r;
  logic [PW-1:0]          prod_r;
  logic [KELVIN_BITS-1:0] res_kelvin_r;
  status_t                res_status_r;
  logic [KELVIN_BITS-1:0] out_kelvin_r;
  status_t                out_status_r;

  logic [W-1:0]               step_rom [W+1];
  logic signed [SAMPLE_BITS+1:0] d_s;
  logic                       zero_rd;
  logic                       bad_div;
  logic [YW-1:0]              y_a;
  logic [YW-1:0]              y_d;
  logic [YW-1:0]              l_mag;
  logic [YW:0]                l_rnd;
  logic [VW-1:0]              prod_ext;
  logic [VW-1:0]              v;
  logic [VW-1:0]              q;
  logic [KELVIN_BITS-1:0]     kelvin_calc;

  for (genvar g = 0; g <= W; g++) begin : g_rom
    localparam logic [63:0] StepQ = ln_step_q(g, W);
    assign step_rom[g] = StepQ[W-1:0];
  end

  assign d_s = $signed({1'b0, held_b_r, 1'b0}) - $signed({2'b00, held_a_r});
  assign zero_rd = (held_a_r == '0);
  assign bad_div = d_s[SAMPLE_BITS+1] || (d_s == '0);

  assign status.fault     = zero_rd || bad_div;
  assign status.last_step = (step_cnt_r == IW'(W));

  ntc_ln_unit #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_ln_a (
    .clk      (clk),
    .load     (cmd.check),
    .step     (cmd.ln_step),
    .resid    (cmd.ln_resid),
    .n        ({1'b0, held_a_r}),
    .shift_idx(step_cnt_r),
    .step_val (step_rom[step_cnt_r]),
    .y        (y_a)
  );

  ntc_ln_unit #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_ln_d (
    .clk      (clk),
    .load     (cmd.check),
    .step     (cmd.ln_step),
    .resid    (cmd.ln_resid),
    .n        (d_s[SAMPLE_BITS:0]),
    .shift_idx(step_cnt_r),
    .step_val (step_rom[step_cnt_r]),
    .y        (y_d)
  );

  // sign-magnitude ln(A) - ln(D), rounded half away from zero
  assign l_mag = (y_a >= y_d) ? (y_a - y_d) : (y_d - y_a);
  assign l_rnd = {1'b0, l_mag} + (YW + 1)'(1 << (GUARD_BITS - 1));

  assign prod_ext = VW'(prod_r);

  always_comb begin
    v = lr_neg_r ? (BaseV + prod_ext) : (BaseV - prod_ext);
    q = v >> QS;
    if (!lr_neg_r && (prod_ext >= BaseV)) begin
      kelvin_calc = '0;
    end else if (q > VW'(KELVIN_MAX)) begin
      kelvin_calc = KELVIN_MAX;
    end else begin
      kelvin_calc = q[KELVIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_a_r <= '0;
      held_b_r <= '0;
    end else if (cmd.capture) begin
      if (sample_a_ok) held_a_r <= sample_a;
      if (sample_b_ok) held_b_r <= sample_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      step_cnt_r   <= IW'(1);
      res_kelvin_r <= '0;
      if (zero_rd) begin
        res_status_r <= STATUS_ZERO_READING;
      end else if (bad_div) begin
        res_status_r <= STATUS_BAD_DIVIDER;
      end else begin
        res_status_r <= STATUS_OK;
      end
    end else if (cmd.ln_step) begin
      step_cnt_r <= step_cnt_r + IW'(1);
    end
    if (cmd.round_en) begin
      lr_neg_r <= (y_a < y_d);
      lr_mag_r <= l_rnd[YW:GUARD_BITS];
    end
    if (cmd.mul_en) begin
      prod_r <= lr_mag_r * SCALE_K;
    end
    if (cmd.scale_en) begin
      res_kelvin_r <= kelvin_calc;
    end
    if (cmd.out_load) begin
      out_kelvin_r <= res_kelvin_r;
      out_status_r <= res_status_r;
    end
  end

  assign kelvin_tenths = out_kelvin_r;
  assign status_code   = out_status_r;

endmodule

`default_nettype wire

// ===== design/ntc_ctrl.sv =====
`default_nettype none

module ntc_ctrl import ntc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output cmd_t            cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  // output register can take a word this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:   if (in_valid) state_nxt = CS_CHECK;
      CS_CHECK:  state_nxt = status.fault ? CS_FINISH : CS_LN;
      CS_LN:     if (status.last_step) state_nxt = CS_RESID;
      CS_RESID:  state_nxt = CS_ROUND;
      CS_ROUND:  state_nxt = CS_MUL;
      CS_MUL:    state_nxt = CS_SCALE;
      CS_SCALE:  state_nxt = CS_FINISH;
      CS_FINISH: if (out_free) state_nxt = CS_IDLE;
      default:   state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        // no word is taken while reset is held
        in_ready    = rst_n;
        cmd.capture = in_valid && rst_n;
      end
      CS_CHECK:  cmd.check    = 1'b1;
      CS_LN:     cmd.ln_step  = 1'b1;
      CS_RESID:  cmd.ln_resid = 1'b1;
      CS_ROUND:  cmd.round_en = 1'b1;
      CS_MUL:    cmd.mul_en   = 1'b1;
      CS_SCALE:  cmd.scale_en = 1'b1;
      CS_FINISH: cmd.out_load = out_free;
      default:   cmd          = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/ntc_divider_temperature_unit.sv =====
// NTC divider temperature converter.
// in_ch carries one word per conversion pair: readings A and B, each with an
// ok flag. A reading whose flag is low is replaced by the one held from an
// earlier word. out_ch returns one word per input word: kelvin_tenths and
// status (ok, bad divider when 2B <= A, zero reading when A = 0; value 0 on
// either fault).
// Both handshakes complete on a rising edge with valid and ready high.
// in_ch.ready is high only while the unit is idle; one word is in work at a
// time. Work on a good pair takes LOG_FRAC_BITS + GUARD_BITS iterations of
// the two log units (24 at defaults), run side by side, plus the check,
// residual, rounding, multiply, scale and handoff steps. A fault pair goes
// from the check straight to the handoff. The log iteration count sets the
// rate.
// The finished word sits in an output register, so a stalled receiver holds
// only the next word's handoff; the next pair is accepted meanwhile.
// Reset (rst_n low at a clock edge) clears the held readings to 0 and drops
// out_ch.valid; a first word with both flags low reports a zero reading.
`default_nettype none

module ntc_divider_temperature_unit import ntc_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ntc_in_if.sink     in_ch,
  ntc_out_if.source  out_ch
);

  cmd_t       cmd;
  dp_status_t dp_status;
  status_t    status_code;

  ntc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (dp_status),
    .cmd      (cmd)
  );

  ntc_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (dp_status),
    .sample_a     (in_ch.sample_a),
    .sample_a_ok  (in_ch.sample_a_ok),
    .sample_b     (in_ch.sample_b),
    .sample_b_ok  (in_ch.sample_b_ok),
    .kelvin_tenths(out_ch.kelvin_tenths),
    .status_code  (status_code)
  );

  assign out_ch.status = status_code;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ntc_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int WORK_BITS    = FRAC_BITS + 8;
  localparam int SETTLE       = 40;
  localparam int PHASE_ITEMS  = 150;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TEMP_CEILING = 6000;

  typedef struct {
    logic [KELVIN_BITS-1:0] kelvin;
    status_t                status;
  } temp_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // held readings as the unit should see them
  logic [11:0] last_a = '0;
  logic [11:0] last_b = '0;

  // Q24 log tables and Q16 scale
  longint unsigned ln_inc_rom [1:WORK_BITS];
  longint unsigned ln2_work;
  longint          k_scale;

  temp_word_t temp_due[$];

  ntc_in_if  in_ch();
  ntc_out_if out_ch();

  assign out_ch.ready = sink_ready;

  ntc_divider_temperature_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // atanh(1/d) in Q60
  function automatic longint unsigned atanh_q60(input longint unsigned d);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned div;
    term = (64'd1 << 60) / d;
    sum  = 0;
    div  = 1;
    while (term != 0) begin
      sum  = sum + term / div;
      term = term / d / d;
      div  = div + 2;
    end
    return sum;
  endfunction

  function automatic longint unsigned q60_round(input longint unsigned x);
    return (x + (64'd1 << (60 - WORK_BITS - 1))) >> (60 - WORK_BITS);
  endfunction

  task automatic init_log_tables();
    longint unsigned ln_q40;
    ln2_work = q60_round(2 * atanh_q60(3));
    for (int i = 1; i <= WORK_BITS; i++) begin
      ln_inc_rom[i] = q60_round(2 * atanh_q60((64'd1 << (i + 1)) + 1));
    end
    // ln(25/24) = 2 atanh(1/49)
    ln_q40  = (2 * atanh_q60(49) + (64'd1 << 19)) >> 20;
    k_scale = longint'(((64'd10 << 56) + (ln_q40 >> 1)) / ln_q40);
  endtask

  // ln(n) in Q24 by normalize and multiplicative steps
  function automatic longint unsigned ln_work(input longint unsigned n);
    int              k;
    longint unsigned m;
    longint unsigned p;
    longint unsigned y;
    longint unsigned t;
    k = 0;
    while (k < 62 && (n >> (k + 1)) != 0) k++;
    m = (n << WORK_BITS) >> k;
    p = 64'd1 << WORK_BITS;
    y = longint'(k) * ln2_work;
    for (int i = 1; i <= WORK_BITS; i++) begin
      t = p + (p >> i);
      if (t <= m) begin
        p = t;
        y = y + ln_inc_rom[i];
      end
    end
    return y + (m - p);
  endfunction

  function automatic temp_word_t convert_pair(input logic [11:0] a, input logic [11:0] b);
    temp_word_t w;
    longint     d;
    longint     diff;
    longint     rounded;
    longint     acc;
    longint     tenths;
    w.kelvin = '0;
    d = 2 * longint'(b) - longint'(a);
    if (a == 0) begin
      w.status = STATUS_ZERO_READING;
    end else if (d <= 0) begin
      w.status = STATUS_BAD_DIVIDER;
    end else begin
      w.status = STATUS_OK;
      diff = longint'(ln_work(longint'(a))) - longint'(ln_work(d));
      if (diff >= 0) rounded = (diff + 128) >>> 8;
      else rounded = -((-diff + 128) >>> 8);
      acc = (longint'(5963) <<< (FRAC_BITS + 15)) - rounded * k_scale;
      if (acc <= 0) tenths = 0;
      else tenths = acc >>> (FRAC_BITS + 16);
      if (tenths > TEMP_CEILING) tenths = TEMP_CEILING;
      w.kelvin = tenths[KELVIN_BITS-1:0];
    end
    return w;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one word in, with random idle cycles ahead of it
  task automatic send_pair(input logic [11:0] a, input bit a_ok,
                           input logic [11:0] b, input bit b_ok);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.sample_a    = a;
    in_ch.sample_a_ok = a_ok;
    in_ch.sample_b    = b;
    in_ch.sample_b_ok = b_ok;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (a_ok) last_a = a;
    if (b_ok) last_b = b;
    temp_due.push_back(convert_pair(last_a, last_b));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (temp_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // held readings start at zero
  task automatic test_after_reset();
    send_pair(12'hABC, 1'b0, 12'h123, 1'b0);
    send_pair(12'h000, 1'b1, 12'hFFF, 1'b1);
    send_pair(12'h800, 1'b1, 12'h000, 1'b0);
  endtask

  task automatic test_directed();
    send_pair(12'd4095, 1'b1, 12'd4095, 1'b1);
    send_pair(12'd1,    1'b1, 12'd4095, 1'b1);
    send_pair(12'd4095, 1'b1, 12'd2048, 1'b1);
    send_pair(12'd1,    1'b1, 12'd1,    1'b1);
    send_pair(12'd2048, 1'b1, 12'd2048, 1'b1);
    send_pair(12'd1024, 1'b1, 12'd1023, 1'b1);
    send_pair(12'd2047, 1'b1, 12'd2048, 1'b1);
    send_pair(12'd3000, 1'b1, 12'd1600, 1'b1);
    // 2B == A and 2B < A
    send_pair(12'd4094, 1'b1, 12'd2047, 1'b1);
    send_pair(12'd4095, 1'b1, 12'd0,    1'b1);
    // zero reading wins over bad divider
    send_pair(12'd0,    1'b1, 12'd4095, 1'b1);
    send_pair(12'd0,    1'b1, 12'd0,    1'b1);
    // flag combinations against held values
    send_pair(12'd3000, 1'b1, 12'd1600, 1'b1);
    send_pair(12'd0,    1'b0, 12'd4095, 1'b1);
    send_pair(12'd100,  1'b1, 12'd0,    1'b0);
    send_pair(12'hFFF,  1'b0, 12'hFFF,  1'b0);
    send_pair(12'd2731, 1'b1, 12'd1366, 1'b1);
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall, input int count);
    logic [11:0] a;
    logic [11:0] b;
    bit          a_ok;
    bit          b_ok;
    int          kind;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // valid divider, occasionally a dropped conversion
        a    = 12'($urandom_range(1, 4095));
        b    = 12'($urandom_range(a / 2 + 1, 4095));
        a_ok = ($urandom_range(0, 9) != 0);
        b_ok = ($urandom_range(0, 9) != 0);
      end else if (kind < 9) begin
        a    = 12'($urandom);
        b    = 12'($urandom);
        a_ok = 1'($urandom);
        b_ok = 1'($urandom);
      end else begin
        a    = 12'($urandom_range(0, 15));
        b    = 12'($urandom_range(0, 15));
        a_ok = 1'b1;
        b_ok = 1'b1;
      end
      send_pair(a, a_ok, b, b_ok);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(50, 0, PHASE_ITEMS);
    run_phase(0, 50, PHASE_ITEMS);
    run_phase(21, 21, PHASE_ITEMS);
  endtask

  always @(negedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    temp_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (temp_due.size() == 0) begin
        log_mismatch($sformatf("word with nothing pending: kelvin %0d status %0d",
                               out_ch.kelvin_tenths, out_ch.status));
      end else begin
        w = temp_due.pop_front();
        if (out_ch.kelvin_tenths !== w.kelvin)
          log_mismatch($sformatf("kelvin_tenths %0d, want %0d",
                                 out_ch.kelvin_tenths, w.kelvin));
        if (out_ch.status !== w.status)
          log_mismatch($sformatf("status %0d, want %s", out_ch.status, w.status.name()));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count, temp_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.sample_a    = '0;
    in_ch.sample_a_ok = 1'b0;
    in_ch.sample_b    = '0;
    in_ch.sample_b_ok = 1'b0;
    init_log_tables();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_directed();
    // sender holds off until everything is back
    wait_drained();
    test_random_phases();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ntc_pkg.sv
design/ntc_in_if.sv
design/ntc_out_if.sv
design/ntc_ln_unit.sv
design/ntc_datapath.sv
design/ntc_ctrl.sv
design/ntc_divider_temperature_unit.sv
test/testbench.sv
